>>> hw/rtl/sof_pkg.sv
package sof_pkg;

  // default sizes
  localparam int MAX_PATTERN_DEF   = 16;
  localparam int POSITION_BITS_DEF = 16;

  // fixed field widths
  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int LEN_W      = 5;
  localparam int SINCE_W    = 5;
  localparam int COUNT_W    = 16;
  localparam int START_W    = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [SINCE_W-1:0] SINCE_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_FIRST = 2'd0,
    CFG_PAT_LAST  = 2'd1,
    CFG_PAT_LEN   = 2'd2
  } cfg_reg_t;

  // pattern byte i of the two pattern words, zero beyond the sixteenth
  function automatic logic [BYTE_W-1:0] pattern_byte(
    input logic [CFG_DATA_W-1:0] first_w,
    input logic [CFG_DATA_W-1:0] last_w,
    input logic [LEN_W-1:0]      i
  );
    logic [5:0] sel;
    sel = {i[2:0], 3'b000};
    case (i[4:3])
      2'd0:    pattern_byte = first_w[sel +: BYTE_W];
      2'd1:    pattern_byte = last_w[sel +: BYTE_W];
      default: pattern_byte = '0;
    endcase
  endfunction

endpackage

>>> hw/rtl/substring_occurrence_finder.sv
// substring occurrence finder
// in channel: one text byte per request, in_tdata[7:0]; in_tuser is the start
//   mark of a new text (clears window, position, match count and end flag).
//   a zero byte ends the text; later bytes are ignored until a start mark.
// out channel: exactly one result per input request, in request order.
// config port: cfg_we writes cfg_wdata into register cfg_index (0 pattern
//   bytes 0..7, 1 pattern bytes 8..15, 2 pattern length); write only while idle.
// result: the result of an accepted request is registered and shows on the out
//   channel in the cycle after its handshake.
// throughput: one request per cycle while out_tready is high. the whole window
//   is compared against the pattern in parallel in the single stage between
//   the input handshake and the result register.
// stall: the result register holds while out_tready is low; a new request is
//   taken in the same cycle that the held result leaves, so a stalled receiver
//   throttles the input directly, without loss or repeat.
// reset: rst_n low at a clock edge clears the pattern registers, the text
//   state and the result valid flag.
module substring_occurrence_finder #(
  parameter int MAX_PATTERN   = sof_pkg::MAX_PATTERN_DEF,
  parameter int POSITION_BITS = sof_pkg::POSITION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [sof_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sof_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sof_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] text_byte
  input  logic                            in_tuser,   // [0] text_start
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] match_found, [16:1] match_start, [32:17] match_total,
  // [33] text_ended, [39:34] zero
  output logic [sof_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import sof_pkg::*;

  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  // configuration
  logic [CFG_DATA_W-1:0] pat_first_r;
  logic [CFG_DATA_W-1:0] pat_last_r;
  logic [LEN_W-1:0]      pat_len_r;

  // text state
  logic [BYTE_W-1:0]        win_r   [MAX_PATTERN];
  logic [BYTE_W-1:0]        win_nxt [MAX_PATTERN];
  logic [BYTE_W-1:0]        win_b   [MAX_PATTERN];
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_b;
  logic [SINCE_W-1:0]       since_r, since_nxt, since_b;
  logic [COUNT_W-1:0]       count_r, count_nxt, count_b;
  logic                     ended_r, ended_nxt, ended_b;

  // result register
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                     in_fire;
  logic [BYTE_W-1:0]        text_byte;
  logic                     text_start;
  logic [LEN_W-1:0]         len;
  logic [POSITION_BITS:0]   here_p1;
  logic                     win_full;
  logic                     win_equal;
  logic                     found;
  logic [POSITION_BITS-1:0] first_pos;
  logic [31:0]              first_wide;
  logic [START_W-1:0]       match_start;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign text_byte  = in_tdata[BYTE_W-1:0];
  assign text_start = in_tuser;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // effective pattern length, clamped to the window depth
  always_comb begin
    if (int'(pat_len_r) > MAX_PATTERN) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = pat_len_r;
    end
  end

  // start mark clears the text state before this byte is handled
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_b[k] = text_start ? '0 : win_r[k];
    end
    pos_b   = text_start ? '0 : pos_r;
    since_b = text_start ? SINCE_MAX : since_r;
    count_b = text_start ? '0 : count_r;
    ended_b = text_start ? 1'b0 : ended_r;
  end

  // one byte through the window compare
  always_comb begin
    win_nxt   = win_b;
    pos_nxt   = pos_b;
    since_nxt = since_b;
    count_nxt = count_b;
    ended_nxt = ended_b;
    found     = 1'b0;
    first_pos = '0;
    here_p1   = {1'b0, pos_b} + 1'b1;
    win_full  = (len != '0) && (here_p1 >= (POSITION_BITS+1)'(len));
    win_equal = win_full;

    // shifted window, newest byte at entry zero
    win_nxt[0] = text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_b[k-1];
    end

    // entry k holds the byte that must equal pattern byte len-1-k
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (k < int'(len)) begin
        if (win_nxt[k] != pattern_byte(pat_first_r, pat_last_r, LEN_W'(int'(len) - 1 - k)))
        begin
          win_equal = 1'b0;
        end
      end
    end

    if (!ended_b) begin
      if (text_byte == '0) begin
        ended_nxt = 1'b1;
        win_nxt   = win_b;
      end else begin
        if (since_b != SINCE_MAX) begin
          since_nxt = since_b + 1'b1;
        end
        // matches never overlap: the last match must lie at least len bytes back
        if (win_equal && ((since_nxt >= len) || (since_nxt == SINCE_MAX))) begin
          found     = 1'b1;
          first_pos = (pos_b == PosMax) ? pos_b : POSITION_BITS'(here_p1 - len);
          since_nxt = '0;
          if (count_b != COUNT_MAX) begin
            count_nxt = count_b + 1'b1;
          end
        end
        if (pos_b != PosMax) begin
          pos_nxt = pos_b + 1'b1;
        end
      end
    end else begin
      win_nxt = win_b;
    end

    // start position saturates to the field width
    first_wide  = 32'(first_pos);
    match_start = (first_wide > 32'h0000_FFFF) ? '1 : first_wide[START_W-1:0];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_first_r <= '0;
      pat_last_r  <= '0;
      pat_len_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_FIRST: pat_first_r <= cfg_wdata;
        CFG_PAT_LAST:  pat_last_r  <= cfg_wdata;
        CFG_PAT_LEN:   pat_len_r   <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // text state advances on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_r[k] <= '0;
      end
      pos_r   <= '0;
      since_r <= SINCE_MAX;
      count_r <= '0;
      ended_r <= 1'b0;
    end else if (in_fire) begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      since_r <= since_nxt;
      count_r <= count_nxt;
      ended_r <= ended_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_fire) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= {6'b0, ended_nxt, count_nxt, match_start, found};
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int WIN_BYTES    = sof_pkg::MAX_PATTERN_DEF;
  localparam int IDLE_PCT     = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 150;
  // one long text that matches on every byte, sent back to back
  localparam int LONG_BYTES   = 200;
  localparam int REPORT_LIMIT = 10;

  localparam logic [15:0] POS_LAST = 16'hFFFF;

  // one result, packed the way out_tdata carries it from bit 0 up
  typedef struct packed {
    logic        ended;
    logic [15:0] total;
    logic [15:0] start;
    logic        found;
  } find_result_t;

  localparam int PAD_W = sof_pkg::OUT_DATA_W - $bits(find_result_t);

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [sof_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [sof_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [sof_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // [7:0] text_byte
  logic                           in_tuser   = 1'b0; // [0] text_start
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [0] match_found, [16:1] match_start, [32:17] match_total, [33] text_ended
  logic [sof_pkg::OUT_DATA_W-1:0] out_tdata;

  // mirror of the pattern registers
  logic [63:0] pat_lo_word;
  logic [63:0] pat_hi_word;
  logic [4:0]  pat_len;

  // mirror of the per-text search state, newest byte at recent[0]
  logic [7:0]  recent [WIN_BYTES];
  logic [15:0] text_pos;
  logic [4:0]  since_match;
  logic [15:0] match_count;
  logic        text_done;

  // results owed by the block, oldest first
  find_result_t expected_finds [$];

  int unsigned failure_count = 0;
  int unsigned requests_sent = 0;

  // random idling on both channels, and the long receiver hold-off
  logic idle_on = 1'b1;
  logic rx_hold = 1'b0;

  substring_occurrence_finder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // search predictor
  // ---------------------------------------------------------------------------

  // pattern byte idx, byte 0 in the low bits of the first word
  function automatic logic [7:0] pat_byte_at(int idx);
    if (idx < 8) return pat_lo_word[8*idx +: 8];
    return pat_hi_word[8*(idx-8) +: 8];
  endfunction

  // a new text empties the window and lifts any block left by an old match
  function automatic void clear_text_state();
    int k;
    for (k = 0; k < WIN_BYTES; k++) recent[k] = '0;
    text_pos    = '0;
    since_match = sof_pkg::SINCE_MAX;
    match_count = '0;
    text_done   = 1'b0;
  endfunction

  // advance the mirrored state by one text byte and return what the block owes
  function automatic find_result_t predict_search_step(logic [7:0] text_byte,
                                                       logic       text_start);
    find_result_t res;
    int           n;
    int           k;
    logic         hit;
    logic [15:0]  here;
    res = '0;
    if (text_start) clear_text_state();
    if (!text_done) begin
      if (text_byte == 8'h00) begin
        // end of text: the zero byte never enters the window
        text_done = 1'b1;
      end else begin
        // lengths above the window width act as a full window
        n    = (pat_len > WIN_BYTES) ? WIN_BYTES : int'(pat_len);
        here = text_pos;
        for (k = WIN_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = text_byte;
        if (since_match != sof_pkg::SINCE_MAX) since_match++;
        // no match until the window holds at least n bytes of this text
        hit = (n > 0) && (int'(here) + 1 >= n);
        for (k = 0; k < n; k++)
          if (recent[k] != pat_byte_at(n - 1 - k)) hit = 1'b0;
        // a match must not overlap the previous one; the top value means no block
        if (hit && (since_match >= n || since_match == sof_pkg::SINCE_MAX)) begin
          res.found   = 1'b1;
          // once the position is stuck at its top the start reads as that top
          res.start   = (here == POS_LAST) ? here : here + 16'd1 - 16'(n);
          since_match = '0;
          if (match_count != sof_pkg::COUNT_MAX) match_count++;
        end
        if (text_pos != POS_LAST) text_pos++;
      end
    end
    res.total = match_count;
    res.ended = text_done;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers
  // ---------------------------------------------------------------------------

  // receiver: random stalls, or a hard hold-off while rx_hold is up
  always @(posedge clk) begin
    if (rx_hold)
      out_tready <= 1'b0;
    else if (idle_on)
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    else
      out_tready <= 1'b1;
  end

  // offer one text byte, wait for the handshake and log the owed result
  task automatic send_text_byte(input logic [7:0] text_byte, input logic text_start);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= text_byte;
    in_tuser  <= text_start;
    do @(posedge clk); while (!in_tready);
    expected_finds.push_back(predict_search_step(text_byte, text_start));
    requests_sent++;
  endtask

  // stop offering and let every owed result come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_finds.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one register write, only while the block is idle; we drops on the next step
  task automatic write_reg(input sof_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sof_pkg::CFG_PAT_FIRST: pat_lo_word = value;
      sof_pkg::CFG_PAT_LAST:  pat_hi_word = value;
      sof_pkg::CFG_PAT_LEN:   pat_len     = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // bytes[7:0] is pattern byte 0
  task automatic load_pattern(input logic [127:0] bytes, input logic [63:0] len_word);
    write_reg(sof_pkg::CFG_PAT_FIRST, bytes[63:0]);
    write_reg(sof_pkg::CFG_PAT_LAST,  bytes[127:64]);
    write_reg(sof_pkg::CFG_PAT_LEN,   len_word);
  endtask

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    find_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_finds.size() == 0) begin
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
          $display("%0t: result with no request pending, data %h", $time, out_tdata);
      end else begin
        want = expected_finds.pop_front();
        if (out_tdata !== {{PAD_W{1'b0}}, want}) begin
          failure_count++;
          if (failure_count <= REPORT_LIMIT)
            $display({"%0t: mismatch (expected/actual) found %b/%b start %0d/%0d ",
                      "total %0d/%0d ended %b/%b pad 0/%h"},
                     $time, want.found, out_tdata[0], want.start, out_tdata[16:1],
                     want.total, out_tdata[32:17], want.ended, out_tdata[33],
                     out_tdata[sof_pkg::OUT_DATA_W-1:34]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked texts for the corner cases of the search
  task automatic test_directed_cases();
    int i;
    // zero length after reset: nothing can match
    send_text_byte(8'h78, 1'b1);
    wait_idle();

    // "aa": non-overlapping matches, end of text, bytes after the end
    load_pattern(128'h6161, 64'd2);
    send_text_byte(8'h61, 1'b1);   // window still short
    send_text_byte(8'h61, 1'b0);   // match at 0
    send_text_byte(8'h61, 1'b0);   // overlaps the last match, blocked
    send_text_byte(8'h61, 1'b0);   // match at 2
    send_text_byte(8'h00, 1'b0);   // ends the text
    send_text_byte(8'h61, 1'b0);   // ignored, count held
    wait_idle();

    // "ab": start mark on a zero byte, then a match right after a partial one
    load_pattern(128'h6261, 64'd2);
    send_text_byte(8'h00, 1'b1);
    send_text_byte(8'h61, 1'b1);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);   // match at 1
    wait_idle();

    // full window of all-ones bytes, both pattern words all ones
    load_pattern({128{1'b1}}, 64'd16);
    for (i = 0; i < 16; i++) send_text_byte(8'hFF, i == 0);
    send_text_byte(8'h01, 1'b0);
    wait_idle();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    int i;
    idle_on <= 1'b0;
    load_pattern(128'h6261, 64'd2);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (i = 0; i < 80; i++)
      send_text_byte($urandom_range(1) ? 8'h61 : 8'h62, i == 0);
    wait_idle();
  endtask

  // phases of random patterns; texts mostly built from the pattern and a
  // small alphabet, with broken copies, stray bytes and some pure noise
  task automatic test_random_texts();
    logic [7:0]   sym [3];
    logic [127:0] pat;
    logic [63:0]  len_word;
    logic         lead;
    int unsigned  phase, goal, phase_end, len_eff, body, pick, cut, i, j;
    phase = 0;
    goal  = requests_sent + RANDOM_ITEMS;
    while (requests_sent < goal) begin
      // one phase runs with no idling at all
      idle_on <= (phase != 2);
      for (i = 0; i < 3; i++) sym[i] = 8'($urandom_range(1, 255));
      pat = {$urandom, $urandom, $urandom, $urandom};
      for (i = 0; i < 16; i++)
        if ($urandom_range(4) != 0) pat[8*i +: 8] = sym[$urandom_range(2)];
      case ($urandom_range(9))
        0:       len_eff = 0;
        1:       len_eff = 1;
        2:       len_eff = 16;
        3:       len_eff = $urandom_range(17, 31);
        default: len_eff = $urandom_range(2, 8);
      endcase
      // only the low five bits of the length word count
      len_word = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = len_eff[4:0];
      load_pattern(pat, len_word);
      if (len_eff > WIN_BYTES) len_eff = WIN_BYTES;

      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        if ($urandom_range(19) == 0) begin
          // noise: any byte, start marks anywhere
          for (i = 0; i < 10; i++) send_text_byte(8'($urandom), $urandom_range(1));
        end else begin
          // now and then a text runs on without a start mark
          lead = ($urandom_range(9) != 0);
          body = $urandom_range(8, 50);
          for (i = 0; i < body; i++) begin
            pick = $urandom_range(19);
            if (pick < 2) begin
              send_text_byte(8'($urandom_range(1, 255)), lead);
              lead = 1'b0;
            end else if (pick < 9) begin
              // whole pattern copy, or a prefix of it
              cut = ($urandom_range(3) == 0) ? $urandom_range(len_eff) : len_eff;
              for (j = 0; j < cut; j++) begin
                send_text_byte(pat[8*j +: 8], lead);
                lead = 1'b0;
              end
            end else begin
              send_text_byte(sym[$urandom_range(2)], lead);
              lead = 1'b0;
            end
          end
          if ($urandom_range(9) != 0) begin
            send_text_byte(8'h00, lead);
            if ($urandom_range(4) == 0) send_text_byte(8'($urandom), 1'b0);
          end
        end
      end
      wait_idle();
      phase++;
    end
  endtask

  // one long text matching on every byte, no idling on either side
  task automatic test_long_match();
    logic [127:0] pat;
    int           i;
    idle_on <= 1'b0;
    pat      = {$urandom, $urandom, $urandom, $urandom};
    pat[7:0] = 8'h5A;
    load_pattern(pat, 64'd1);
    for (i = 0; i < LONG_BYTES; i++) send_text_byte(8'h5A, i == 0);
    send_text_byte(8'h00, 1'b0);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    pat_lo_word = '0;
    pat_hi_word = '0;
    pat_len     = '0;
    clear_text_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_backpressure();
    test_random_texts();
    test_long_match();

    wait_idle();
    repeat (5) @(posedge clk);
    if (failure_count == 0 && expected_finds.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // hang guard, several times the slowest expected run
  initial begin
    #(500_000);
    $display("testbench failed");
    $finish;
  end

endmodule
